### rtl/core/dtp_pkg.sv
// Package for the decimal token parser.
// Result status codes, character codes and the result record.
// No dependencies.
package dtp_pkg;

    localparam int MANT_W = 64;
    localparam int FRAC_W = 5;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_QUIT    = 2'd2
    } t_status;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_Q     = 8'h71;

    typedef struct packed {
        t_status             status;
        logic                negative;
        logic [MANT_W-1:0]   mantissa;
        logic [FRAC_W-1:0]   frac_digits;
    } t_result;

endpackage

### rtl/core/dtp_scan.sv
// Per-character token state and token verdict for the decimal token parser.
// Updates the token state on each accepted character; depends on dtp_pkg.
module dtp_scan #(
    parameter int MAX_LEN = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_ch,
    input  logic             i_last_char,
    input  logic             i_quit_enabled,
    output dtp_pkg::t_result o_result
);
    import dtp_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic              r_minus, n_minus;
    logic              r_point, n_point;
    logic              r_err,   n_err;
    logic              r_q,     n_q;
    logic [MANT_W-1:0] r_val,   n_val;
    logic [FRAC_W-1:0] r_icnt,  n_icnt;
    logic [FRAC_W-1:0] r_fcnt,  n_fcnt;

    logic              first;
    logic              is_digit;
    logic [FRAC_W:0]   digit_sum;

    always_comb begin
        first    = (r_pos == '0);
        is_digit = i_ch inside {[CH_ZERO:CH_NINE]};
        n_pos    = r_pos;
        n_minus  = r_minus;
        n_point  = r_point;
        n_err    = r_err;
        n_q      = r_q;
        n_val    = r_val;
        n_icnt   = r_icnt;
        n_fcnt   = r_fcnt;
        if (r_pos >= POS_W'(MAX_LEN)) begin
            n_err = 1'b1;
        end else begin
            if (is_digit) begin
                // x*10 + d as two shifts and adds
                n_val = {r_val[MANT_W-4:0], 3'b000} + {r_val[MANT_W-2:0], 1'b0}
                      + {{(MANT_W-4){1'b0}}, i_ch[3:0]};
                if (r_point) begin
                    n_fcnt = r_fcnt + 1'b1;
                end else begin
                    n_icnt = r_icnt + 1'b1;
                end
            end else if (first && (i_ch == CH_MINUS || i_ch == CH_PLUS)) begin
                if (i_ch == CH_MINUS) begin
                    n_minus = 1'b1;
                end
            end else if (!first && i_ch == CH_POINT) begin
                if (r_point) begin
                    n_err = 1'b1;
                end
                n_point = 1'b1;
            end else begin
                n_err = 1'b1;
            end
            if (first && i_ch == CH_Q) begin
                n_q = 1'b1;
            end
            n_pos = r_pos + 1'b1;
        end
    end

    always_comb begin
        digit_sum            = {1'b0, n_icnt} + {1'b0, n_fcnt};
        o_result.status      = ST_VALID;
        o_result.negative    = n_minus;
        o_result.mantissa    = n_val;
        o_result.frac_digits = n_fcnt;
        if (i_quit_enabled && n_q && n_pos == POS_W'(1)) begin
            o_result.status = ST_QUIT;
        end else if (n_err || digit_sum == '0) begin
            o_result.status = ST_INVALID;
        end
        if (o_result.status != ST_VALID) begin
            o_result.negative    = 1'b0;
            o_result.mantissa    = '0;
            o_result.frac_digits = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_char)) begin
            r_pos   <= '0;
            r_minus <= 1'b0;
            r_point <= 1'b0;
            r_err   <= 1'b0;
            r_q     <= 1'b0;
            r_val   <= '0;
            r_icnt  <= '0;
            r_fcnt  <= '0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_minus <= n_minus;
            r_point <= n_point;
            r_err   <= n_err;
            r_q     <= n_q;
            r_val   <= n_val;
            r_icnt  <= n_icnt;
            r_fcnt  <= n_fcnt;
        end
    end

endmodule

### rtl/core/decimal_token_parser_top.sv
// Top level of the decimal token parser: quit-enable register and result register.
// Instantiates dtp_scan; depends on dtp_pkg.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+------------------------------------------------
//  in      | i_in_valid | o_in_stall  | i_ch, i_last_char
//  out     | o_out_valid| i_out_stall | o_status, o_negative, o_mantissa,
//          |            |             | o_fraction_digits
//  cfg     | i_cfg_we   | -           | i_cfg_wdata (quit enable)
//
// One character per cycle unless the last stalls; verdict valid in the cycle after it.
// The digit accumulate (x*10 + d, shift-add) sets the combinational path.
// Reset is synchronous; it clears token state, quit enable and output valid.
// Characters other than the last are taken while a result is held; a last
// character stalls only while the held result is stalled.
module decimal_token_parser_top #(
    parameter int MAX_LEN = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_ch,
    input  logic                       i_last_char,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic                       o_negative,
    output logic [dtp_pkg::MANT_W-1:0] o_mantissa,
    output logic [dtp_pkg::FRAC_W-1:0] o_fraction_digits,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata
);
    import dtp_pkg::*;

    logic    r_quit_en;
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    t_result scan_res;
    logic    take;
    logic    take_last;

    assign o_in_stall = r_out_valid && i_out_stall && i_last_char;
    assign take       = i_in_valid && !o_in_stall;
    assign take_last  = take && i_last_char;

    dtp_scan #(
        .MAX_LEN (MAX_LEN)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_ch           (i_ch),
        .i_last_char    (i_last_char),
        .i_quit_enabled (r_quit_en),
        .o_result       (scan_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (take_last) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quit_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_quit_en <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_last) begin
            r_out <= scan_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_negative        = r_out.negative;
    assign o_mantissa        = r_out.mantissa;
    assign o_fraction_digits = r_out.frac_digits;

    a_non_number_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_VALID) |->
            (o_mantissa == '0 && !o_negative && o_fraction_digits == '0))
        else $error("non-number result carries payload");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_last |=> o_out_valid)
        else $error("last character gave no result");

    a_mid_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_last_char && !o_out_valid) |=> !o_out_valid)
        else $error("result without last character");

endmodule

### bench/decimal_token_parser_checker.sv
`timescale 1ns / 100ps
// Checker for the decimal token parser: watches the character, result and config channels,
// predicts each token verdict and compares it with the block's result.
// Depends on dtp_pkg.
module decimal_token_parser_checker #(
    parameter int MAX_LEN = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [7:0]                 i_ch,
    input  logic                       i_last_char,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [1:0]                 i_status,
    input  logic                       i_negative,
    input  logic [dtp_pkg::MANT_W-1:0] i_mantissa,
    input  logic [dtp_pkg::FRAC_W-1:0] i_fraction_digits,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    output int                         o_pending,
    output int                         o_fail_count,
    output int                         o_checked
);
    import dtp_pkg::*;

    bit                quit_en;
    logic [4:0]        tok_len;
    bit                tok_minus;
    bit                tok_point;
    bit                tok_bad;
    bit                tok_q;
    logic [MANT_W-1:0] tok_digits;
    logic [4:0]        int_cnt;
    logic [FRAC_W-1:0] frac_cnt;

    t_result verdict_q[$];
    t_result want;
    int      fail_count = 0;
    int      checked = 0;

    task automatic clear_token();
        tok_len = '0;
        tok_minus = 1'b0;
        tok_point = 1'b0;
        tok_bad = 1'b0;
        tok_q = 1'b0;
        tok_digits = '0;
        int_cnt = '0;
        frac_cnt = '0;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last);
        bit      first;
        t_result r;
        first = (tok_len == 0);
        if (tok_len >= MAX_LEN) begin
            tok_bad = 1'b1;
        end else begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                tok_digits = tok_digits * 64'd10 + MANT_W'(c - CH_ZERO);
                if (tok_point) begin
                    frac_cnt = frac_cnt + 1'b1;
                end else begin
                    int_cnt = int_cnt + 1'b1;
                end
            end else if (first && (c == CH_MINUS || c == CH_PLUS)) begin
                if (c == CH_MINUS) tok_minus = 1'b1;
            end else if (!first && c == CH_POINT) begin
                if (tok_point) tok_bad = 1'b1;
                tok_point = 1'b1;
            end else begin
                tok_bad = 1'b1;
            end
            if (first && c == CH_Q) tok_q = 1'b1;
            tok_len = tok_len + 1'b1;
        end
        if (last) begin
            r = '0;
            if (quit_en && tok_q && tok_len == 5'd1) begin
                r.status = ST_QUIT;
            end else if (tok_bad || (int_cnt + frac_cnt) == 0) begin
                r.status = ST_INVALID;
            end else begin
                r.status = ST_VALID;
                r.negative = tok_minus;
                r.mantissa = tok_digits;
                r.frac_digits = frac_cnt;
            end
            verdict_q.push_back(r);
            clear_token();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quit_en = 1'b0;
            clear_token();
            verdict_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result status %0d mant %0d",
                                 $time, i_status, i_mantissa);
                end else begin
                    want = verdict_q.pop_front();
                    checked++;
                    if (i_status != want.status || i_negative != want.negative ||
                        i_mantissa != want.mantissa ||
                        i_fraction_digits != want.frac_digits) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch exp status %0d neg %0b mant %0d frac %0d",
                                     $time, want.status, want.negative, want.mantissa,
                                     want.frac_digits);
                            $display("    got status %0d neg %0b mant %0d frac %0d",
                                     i_status, i_negative, i_mantissa, i_fraction_digits);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) parse_char(i_ch, i_last_char);
            if (i_cfg_we) quit_en = i_cfg_wdata;
        end
        o_pending <= verdict_q.size();
        o_fail_count <= fail_count;
        o_checked <= checked;
    end

endmodule

### bench/decimal_token_parser_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for decimal_token_parser_top: directed and random tokens, random gaps
// and output stalls, quit enable switched between phases. Uses decimal_token_parser_checker.
module decimal_token_parser_top_tb;
    import dtp_pkg::*;

    localparam int MAX_LEN = 19;
    localparam int ITEM_TARGET = 1750;
    localparam int DRAIN_CYCLES = 6;
    localparam int IDLE_LIMIT = 2000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        ch = '0;
    logic              last_char = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic              negative;
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] frac_digits;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;

    int chk_pending;
    int chk_fails;
    int chk_checked;

    logic [7:0] token[$];
    int chars_sent = 0;
    int tokens_sent = 0;
    int directed_chars;
    int idle_cycles = 0;
    int stall_left = 0;
    int calm_results = 0;
    int hold;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    decimal_token_parser_top #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_ch             (ch),
        .i_last_char      (last_char),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_negative       (negative),
        .o_mantissa       (mantissa),
        .o_fraction_digits(frac_digits),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata)
    );

    decimal_token_parser_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_ch             (ch),
        .i_last_char      (last_char),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_status         (status),
        .i_negative       (negative),
        .i_mantissa       (mantissa),
        .i_fraction_digits(frac_digits),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .o_pending        (chk_pending),
        .o_fail_count     (chk_fails),
        .o_checked        (chk_checked)
    );

    // result side: stall counted only while a result is offered
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (out_valid) begin
            if (!out_stall) begin
                if (calm_results != 0) begin
                    calm_results--;
                    hold = 0;
                end else begin
                    hold = $urandom_range(0, 8);
                    if ($urandom_range(0, 15) == 0) calm_results = $urandom_range(8, 24);
                end
                stall_left <= hold;
                out_stall <= (hold != 0);
            end else begin
                stall_left <= stall_left - 1;
                out_stall <= (stall_left > 1);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("decimal_token_parser_top_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last, input int gap);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        last_char <= last;
        do @(posedge clk); while (in_stall);
        chars_sent++;
    endtask

    task automatic send_token();
        int gap_max;
        gap_max = ($urandom_range(0, 4) == 0) ? 0 : 8;
        foreach (token[k])
            send_char(token[k], k == token.size() - 1, $urandom_range(0, gap_max));
        tokens_sent++;
    endtask

    task automatic send_text(input string s);
        token.delete();
        for (int k = 0; k < s.len(); k++) token.push_back(s[k]);
        send_token();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (chk_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_quit(input logic v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic make_number();
        int n_dig;
        int pt;
        token.delete();
        case ($urandom_range(0, 2))
            1: token.push_back(CH_PLUS);
            2: token.push_back(CH_MINUS);
            default: ;
        endcase
        n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_LEN) : $urandom_range(1, 6);
        pt = $urandom_range(0, 1) ? $urandom_range(0, n_dig) : -1;
        for (int k = 0; k < n_dig; k++) begin
            if (k == pt) token.push_back(CH_POINT);
            token.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if (pt == n_dig) token.push_back(CH_POINT);
    endtask

    task automatic make_token();
        int kind;
        int pos;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            make_number();
        end else if (kind < 75) begin
            make_number();
            pos = $urandom_range(0, token.size() - 1);
            case ($urandom_range(0, 3))
                0: token[pos] = CH_POINT;
                1: token[pos] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                2: token.insert(pos, 8'($urandom_range(0, 255)));
                default: token.insert(pos, CH_POINT);
            endcase
        end else if (kind < 85) begin
            token.delete();
            repeat ($urandom_range(MAX_LEN + 1, MAX_LEN + 5))
                token.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (kind < 93) begin
            token.delete();
            token.push_back(CH_Q);
            if ($urandom_range(0, 2) == 0) token.push_back(8'($urandom_range(0, 255)));
        end else begin
            token.delete();
            repeat ($urandom_range(1, 5)) token.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        set_quit(1'b0);
        send_text("0");
        send_text("9");
        send_text("-0");
        send_text("+5");
        send_text("5.");
        send_text("1.5");
        send_text("12.345");
        send_text("9999999999999999999");
        send_text("+.12345678901234567");
        send_text("99999999999999999999");
        send_text(".5");
        send_text("+");
        send_text("-");
        send_text("-.");
        send_text("1..2");
        send_text("1+2");
        send_text("12a");
        send_text("q");
        token = '{CH_NINE, 8'h00};
        send_token();
        token = '{8'hFF};
        send_token();

        set_quit(1'b1);
        send_text("q");
        send_text("qq");
        send_text("Q");
        send_text("-q");

        directed_chars = chars_sent;
        for (int p = 0; p < 4; p++) begin
            set_quit(p[0]);
            while (chars_sent < directed_chars + (p + 1) * ITEM_TARGET / 4) begin
                make_token();
                send_token();
            end
        end
        wait_idle();

        $display("%0d characters in %0d tokens, quit enable toggled across phases",
                 chars_sent, tokens_sent);
        $display("%0d verdicts compared, %0d mismatches", chk_checked, chk_fails);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("decimal_token_parser_top_tb: clean");
        end else begin
            $display("decimal_token_parser_top_tb: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/dtp_pkg.sv
rtl/core/dtp_scan.sv
rtl/core/decimal_token_parser_top.sv
bench/decimal_token_parser_checker.sv
bench/decimal_token_parser_top_tb.sv
